FILE: rtl/core/mdf_pkg.sv
// Shared types and constants for the 32x32/32 multiply-divide block.
package mdf_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned HalfW    = WordW / 2;
  localparam int unsigned RemW     = WordW - 1;
  localparam int unsigned DivSteps = WordW;

  typedef struct packed {
    logic [WordW-1:0] factor_a;
    logic [WordW-1:0] factor_b;
    logic [WordW-1:0] divisor;
  } in_beat_t;

  typedef struct packed {
    logic [WordW-1:0] quotient;
    logic             fault;
  } out_beat_t;

  // Partial remainder, shifting dividend/quotient word, divisor, fault.
  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [WordW-1:0] shreg;
    logic [RemW-1:0]  dvs;
    logic             fault;
  } div_beat_t;

endpackage

FILE: rtl/core/mdf_mul_front.sv
// Three-stage front end: partial products, product sum, fault check and division setup.
module mdf_mul_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              up_valid_i,
  output logic              up_ready_o,
  input  mdf_pkg::in_beat_t up_data_i,
  output logic              dn_valid_o,
  input  logic              dn_ready_i,
  output mdf_pkg::div_beat_t dn_data_o
);
  import mdf_pkg::*;

  typedef struct packed {
    logic [WordW-1:0] ll;
    logic [WordW-1:0] lh;
    logic [WordW-1:0] hl;
    logic [WordW-1:0] hh;
    logic [WordW-1:0] dv;
  } pp_t;

  typedef struct packed {
    logic [2*WordW-1:0] prod;
    logic [WordW-1:0]   dv;
  } prod_t;

  logic      v1_q, v2_q, v3_q;
  logic      rdy1, rdy2, rdy3;
  pp_t       pp_d, pp_q;
  prod_t     pr_d, pr_q;
  div_beat_t db_d, db_q;
  logic [WordW-1:0] high, low;

  assign rdy3       = !v3_q || dn_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign up_ready_o = rdy1;

  always_comb begin
    pp_d.ll = up_data_i.factor_a[HalfW-1:0]     * up_data_i.factor_b[HalfW-1:0];
    pp_d.lh = up_data_i.factor_a[HalfW-1:0]     * up_data_i.factor_b[WordW-1:HalfW];
    pp_d.hl = up_data_i.factor_a[WordW-1:HalfW] * up_data_i.factor_b[HalfW-1:0];
    pp_d.hh = up_data_i.factor_a[WordW-1:HalfW] * up_data_i.factor_b[WordW-1:HalfW];
    pp_d.dv = up_data_i.divisor;
  end

  always_comb begin
    pr_d.prod = {pp_q.hh, pp_q.ll}
              + {{HalfW{1'b0}}, pp_q.lh, {HalfW{1'b0}}}
              + {{HalfW{1'b0}}, pp_q.hl, {HalfW{1'b0}}};
    pr_d.dv   = pp_q.dv;
  end

  // High word below the divisor means the top half of the division yields
  // zero bits and leaves the high word as the partial remainder.
  assign high = pr_q.prod[2*WordW-1:WordW];
  assign low  = pr_q.prod[WordW-1:0];

  always_comb begin
    db_d.fault = (pr_q.dv == '0) || pr_q.dv[WordW-1] || (high >= pr_q.dv);
    db_d.rem   = high[RemW-1:0];
    db_d.shreg = low;
    db_d.dvs   = pr_q.dv[RemW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= up_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && up_valid_i) pp_q <= pp_d;
    if (rdy2 && v1_q)       pr_q <= pr_d;
    if (rdy3 && v2_q)       db_q <= db_d;
  end

  assign dn_valid_o = v3_q;
  assign dn_data_o  = db_q;

endmodule

FILE: rtl/core/mdf_div_cell.sv
// One restoring-division cell: shift in a dividend bit, compare, subtract.
module mdf_div_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               up_valid_i,
  output logic               up_ready_o,
  input  mdf_pkg::div_beat_t up_data_i,
  output logic               dn_valid_o,
  input  logic               dn_ready_i,
  output mdf_pkg::div_beat_t dn_data_o
);
  import mdf_pkg::*;

  logic             valid_q;
  div_beat_t        data_d, data_q;
  logic [WordW-1:0] trial, diff;
  logic             ge;

  assign up_ready_o = !valid_q || dn_ready_i;

  always_comb begin
    trial        = {up_data_i.rem, up_data_i.shreg[WordW-1]};
    diff         = trial - {1'b0, up_data_i.dvs};
    ge           = trial >= {1'b0, up_data_i.dvs};
    data_d.rem   = ge ? diff[RemW-1:0] : trial[RemW-1:0];
    data_d.shreg = {up_data_i.shreg[WordW-2:0], ge};
    data_d.dvs   = up_data_i.dvs;
    data_d.fault = up_data_i.fault;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) data_q <= data_d;
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

endmodule

FILE: rtl/core/mul_div_u32_with_fault.sv
// Top level: 32x32 multiply, then floor division by a 32-bit divisor with fault flag.
//
//   channel | direction | handshake                | payload
//   in      | input     | in_valid_i / in_ready_o  | in_data_i  (factor_a, factor_b, divisor)
//   out     | output    | out_valid_o / out_ready_i| out_data_o (quotient, fault)
//
// One beat enters per cycle while the output is not stalled; the pipe is three front stages
// (partial products, product sum, fault check) and 32 division cells.
// Throughput is set by the cell row, one quotient bit per cell per cycle.
// Reset empties every stage; payload registers are not reset.
// A stalled output holds its beat; upstream stages keep filling bubbles,
// so input stays ready until every front stage and cell is full.
module mul_div_u32_with_fault (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mdf_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mdf_pkg::out_beat_t out_data_o
);
  import mdf_pkg::*;

  logic      c_valid [DivSteps+1];
  logic      c_ready [DivSteps+1];
  div_beat_t c_data  [DivSteps+1];

  mdf_mul_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (in_valid_i),
    .up_ready_o (in_ready_o),
    .up_data_i  (in_data_i),
    .dn_valid_o (c_valid[0]),
    .dn_ready_i (c_ready[0]),
    .dn_data_o  (c_data[0])
  );

  for (genvar i = 0; i < DivSteps; i++) begin : g_cell
    mdf_div_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (c_valid[i]),
      .up_ready_o (c_ready[i]),
      .up_data_i  (c_data[i]),
      .dn_valid_o (c_valid[i+1]),
      .dn_ready_i (c_ready[i+1]),
      .dn_data_o  (c_data[i+1])
    );
  end

  assign c_ready[DivSteps] = out_ready_i;
  assign out_valid_o       = c_valid[DivSteps];

  // Drop the quotient of a rejected item.
  always_comb begin
    out_data_o.fault    = c_data[DivSteps].fault;
    out_data_o.quotient = c_data[DivSteps].fault ? '0 : c_data[DivSteps].shreg;
  end

endmodule

FILE: rtl/core/mdf_checker.sv
// Port-level checker for the multiply-divide block, bound to the top level.
module mdf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input mdf_pkg::in_beat_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input mdf_pkg::out_beat_t out_data_o
);
  import mdf_pkg::*;

  // A faulted beat carries a zero quotient.
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fault |-> out_data_o.quotient == '0)
    else $error("faulted beat with nonzero quotient");

  // An empty or draining output stage lets every stage advance.
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled while output stage is free");

  // A stalled output beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // Nothing leaves the block right after reset; the pipe is 35 deep.
  a_no_early_out: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid directly after reset");

endmodule

bind mul_div_u32_with_fault mdf_checker u_mdf_checker (.*);

FILE: tb/mul_div_u32_with_fault_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for mul_div_u32_with_fault: scaled multiply-divide with fault flag.
module mul_div_u32_with_fault_tb;
  import mdf_pkg::*;

  localparam logic [WordW-1:0] DivLimit  = 32'h8000_0000;
  localparam logic [WordW-1:0] DivMaxOk  = 32'h7FFF_FFFF;
  localparam logic [WordW-1:0] WordMax   = 32'hFFFF_FFFF;
  localparam int unsigned      NumRandom = 800;
  localparam int unsigned      QuietTail = 80;
  localparam int unsigned      DrainWait = 50;
  localparam int unsigned      CycleCap  = 200000;

  typedef enum int unsigned {
    MixInRange,
    MixZeroDiv,
    MixWideDiv,
    MixOverflow,
    MixAnything
  } mix_e;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      out_ready = 1'b0;
  in_beat_t  in_data   = '0;
  logic      in_ready;
  logic      out_valid;
  out_beat_t out_data;

  in_beat_t  pending_beats[$];
  out_beat_t scaled_q[$];
  logic      in_taken   = 1'b0;
  int        in_gap     = 0;
  int        out_gap    = 0;
  int        err_cnt    = 0;
  int        fault_cnt  = 0;
  int        result_cnt = 0;
  int        cycle_cnt  = 0;

  mul_div_u32_with_fault u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #5 clk_i = ~clk_i;

  // floor(a*b/d), or zero with fault for a bad divisor or a quotient wider than a word
  function automatic out_beat_t scale_mul_div(in_beat_t beat);
    logic [2*WordW-1:0] prod;
    out_beat_t          res;
    prod         = {{WordW{1'b0}}, beat.factor_a} * {{WordW{1'b0}}, beat.factor_b};
    res.quotient = '0;
    res.fault    = 1'b1;
    if (beat.divisor != '0 && beat.divisor < DivLimit &&
        prod[2*WordW-1:WordW] < beat.divisor) begin
      res.quotient = WordW'(prod / {{WordW{1'b0}}, beat.divisor});
      res.fault    = 1'b0;
    end
    return res;
  endfunction

  // Random word with a random number of leading zeros
  function automatic logic [WordW-1:0] rand_word();
    return $urandom() >> $urandom_range(0, WordW - 1);
  endfunction

  task automatic queue_beat(logic [WordW-1:0] a, logic [WordW-1:0] b, logic [WordW-1:0] d);
    in_beat_t beat;
    beat.factor_a = a;
    beat.factor_b = b;
    beat.divisor  = d;
    pending_beats.push_back(beat);
  endtask

  // Driver: present the next beat, or idle in short bursts outside calm windows
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_beats.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_beats.size() > QuietTail && cycle_cnt[7] &&
                   $urandom_range(0, 5) == 0) begin
        in_gap   <= $urandom_range(0, 3);
        in_valid <= 1'b0;
      end else begin
        in_data  <= pending_beats.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Back-pressure on the result side
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap   <= out_gap - 1;
      out_ready <= 1'b0;
    end else if (pending_beats.size() > QuietTail && cycle_cnt[6] &&
                 $urandom_range(0, 4) == 0) begin
      out_gap   <= $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predict on every accepted input beat, check every accepted result beat
  always @(posedge clk_i) begin
    out_beat_t exp_beat;
    cycle_cnt <= cycle_cnt + 1;
    in_taken  <= in_valid && in_ready;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        scaled_q.push_back(scale_mul_div(in_data));
      end
      if (out_valid && out_ready) begin
        result_cnt++;
        if (scaled_q.size() == 0) begin
          $error("result beat with nothing expected: quotient %h fault %b",
                 out_data.quotient, out_data.fault);
          err_cnt++;
        end else begin
          exp_beat = scaled_q.pop_front();
          if (exp_beat.fault) fault_cnt++;
          if (out_data.quotient !== exp_beat.quotient) begin
            $error("quotient: expected %h, actual %h", exp_beat.quotient, out_data.quotient);
            err_cnt++;
          end
          if (out_data.fault !== exp_beat.fault) begin
            $error("fault: expected %b, actual %b", exp_beat.fault, out_data.fault);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_cnt > CycleCap) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycle_cnt, scaled_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [2*WordW-1:0] prod;
    logic [WordW-1:0]   a;
    logic [WordW-1:0]   b;
    logic [WordW-1:0]   d;
    logic [WordW-1:0]   hi;
    mix_e               mix;

    // Divisor out of range
    queue_beat(32'd0, 32'd0, 32'd0);
    queue_beat(WordMax, WordMax, 32'd0);
    queue_beat(32'd1, 32'd1, DivLimit);
    queue_beat(32'd0, WordMax, WordMax);
    queue_beat(32'd3, 32'd5, 32'h8000_0001);
    // Quotient overflow, including the high word equal to the divisor
    queue_beat(WordMax, WordMax, DivMaxOk);
    queue_beat(32'h0001_0000, 32'h0005_0000, 32'd5);
    queue_beat(32'h0001_0000, 32'h0001_0000, 32'd1);
    // Near the range edge: largest quotients, and a high word equal to the divisor
    queue_beat(32'h0001_0000, 32'h0005_0000, 32'd6);
    queue_beat(WordMax, DivMaxOk, DivMaxOk);
    queue_beat(WordMax, 32'd1, 32'd1);
    queue_beat(32'hFFFF_FFFE, 32'h8000_0000, DivMaxOk);
    // Zero and small operands, then mixed bit patterns
    queue_beat(32'd0, 32'd0, 32'd1);
    queue_beat(32'd0, WordMax, DivMaxOk);
    queue_beat(WordMax, 32'd0, 32'd7);
    queue_beat(32'd1, 32'd1, DivMaxOk);
    queue_beat(32'd7, 32'd3, 32'd2);
    queue_beat(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555);
    queue_beat(32'h8000_0000, 32'h8000_0000, 32'h4000_0001);

    for (int i = 0; i < NumRandom; i++) begin
      mix  = mix_e'($urandom_range(0, 9) < 5 ? MixInRange : $urandom_range(1, 4));
      a    = $urandom_range(0, 3) == 0 ? $urandom() : rand_word();
      b    = $urandom_range(0, 3) == 0 ? $urandom() : rand_word();
      prod = {{WordW{1'b0}}, a} * {{WordW{1'b0}}, b};
      hi   = prod[2*WordW-1:WordW];
      unique case (mix)
        MixInRange: begin
          d = hi < DivMaxOk ? $urandom_range(DivMaxOk, hi + 1) : rand_word();
        end
        MixZeroDiv: begin
          d = '0;
        end
        MixWideDiv: begin
          // Force the top bit so the divisor is at least 2^31
          d = DivLimit | rand_word();
        end
        MixOverflow: begin
          d = hi != '0 ? $urandom_range(hi, 1) : rand_word();
        end
        default: begin
          d = $urandom();
        end
      endcase
      queue_beat(a, b, d);
    end

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_beats.size() != 0 || in_valid) @(negedge clk_i);
    while (scaled_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);

    $display("checked %0d result beats (%0d faults) over directed edge cases and %0d random beats",
             result_cnt, fault_cnt, NumRandom);
    $display("stalls and gaps on both channels, %0d cycles", cycle_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/mdf_pkg.sv
rtl/core/mdf_mul_front.sv
rtl/core/mdf_div_cell.sv
rtl/core/mul_div_u32_with_fault.sv
rtl/core/mdf_checker.sv
tb/mul_div_u32_with_fault_tb.sv
